// File: src/phong_fragment_lighting_macros.svh
// assertion helpers shared by the lighting block
`ifndef PHONG_FRAGMENT_LIGHTING_MACROS_SVH
`define PHONG_FRAGMENT_LIGHTING_MACROS_SVH
`ifndef SYNTHESIS
`define PFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/pfl_pkg.sv
package pfl_pkg;

	localparam int COLOR_FRAC_BITS = 12;
	localparam int COLOR_W = COLOR_FRAC_BITS + 1;
	localparam logic [COLOR_W-1:0] COLOR_ONE = COLOR_W'(1) << COLOR_FRAC_BITS;

	localparam int Q14_ONE = 16384;
	localparam int SHIN_W = 8;
	localparam int POW_STEPS = 2 * SHIN_W;
	localparam int SQRT_STEPS = 31;
	localparam int QUO_BITS = 15;
	// magnitude/square, sum, root steps, divider load, divide steps, sign fix-up
	localparam int UV_LAT = 4 + SQRT_STEPS + QUO_BITS;

	localparam logic [2:0] REG_LIGHT_POS = 3'd0;
	localparam logic [2:0] REG_VIEW_POS  = 3'd1;
	localparam logic [2:0] REG_AMBIENT   = 3'd2;
	localparam logic [2:0] REG_DIFFUSE   = 3'd3;
	localparam logic [2:0] REG_SPECULAR  = 3'd4;
	localparam logic [2:0] REG_SHININESS = 3'd5;

	typedef logic signed [16:0] raw_t;
	typedef logic signed [15:0] unit_t;

	typedef struct packed {
		logic [11:0] win_x;
		logic [11:0] win_y;
	} tag_t;

	// positive part of a Q2.28 dot product as Q1.14, capped at 1.0
	function automatic logic [14:0] to_q14(input logic signed [36:0] d);
		logic [22:0] r;
		r = d[36:14];
		if (d <= 37'sd0)
			to_q14 = '0;
		else if (r > 23'(Q14_ONE))
			to_q14 = 15'(Q14_ONE);
		else
			to_q14 = r[14:0];
	endfunction

endpackage

// File: src/pfl_unit_vec.sv
module pfl_unit_vec import pfl_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  raw_t  vec  [3],
	output unit_t unit [3]
);

	localparam int SQ_W = 34;
	localparam int FRAC_SH = 28;
	localparam int N_W = SQ_W + FRAC_SH;
	localparam int REM_W = SQRT_STEPS + 2;
	localparam int DIV_W = 16 + FRAC_SH;

	logic [16:0] neg_v  [3];
	logic [15:0] mag_a  [3];
	logic [15:0] mag_s1 [3];
	logic        neg_s1 [3];
	logic [31:0] sqr_s1 [3];

	logic [SQ_W-1:0]       sq_s   [SQRT_STEPS+1];
	logic [REM_W-1:0]      rem_s  [SQRT_STEPS+1];
	logic [SQRT_STEPS-1:0] root_s [SQRT_STEPS+1];
	logic [15:0]           mag_s  [SQRT_STEPS+1][3];
	logic                  neg_s  [SQRT_STEPS+1][3];

	logic [N_W-1:0]        rad    [SQRT_STEPS];
	logic [REM_W+1:0]      trial  [SQRT_STEPS];
	logic [REM_W+1:0]      sub_v  [SQRT_STEPS];
	logic [REM_W-1:0]      rem_n  [SQRT_STEPS];
	logic [SQRT_STEPS-1:0] root_n [SQRT_STEPS];

	logic [DIV_W-1:0]      drem_s [QUO_BITS+1][3];
	logic [QUO_BITS-1:0]   quo_s  [QUO_BITS+1][3];
	logic [SQRT_STEPS-1:0] len_s  [QUO_BITS+1];
	logic                  dneg_s [QUO_BITS+1][3];

	logic [DIV_W+1:0]      dvs    [QUO_BITS];
	logic [DIV_W-1:0]      drem_n [QUO_BITS][3];
	logic [QUO_BITS-1:0]   quo_n  [QUO_BITS][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_v[i] = 17'd0 - vec[i];
			mag_a[i] = vec[i][16] ? neg_v[i][15:0] : vec[i][15:0];
		end
	end

	// one root bit per stage
	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			rad[k] = {sq_s[k], {FRAC_SH{1'b0}}};
			trial[k] = {rem_s[k], rad[k][N_W-1-2*k -: 2]};
			sub_v[k] = {2'b00, root_s[k], 2'b01};
			if (trial[k] >= sub_v[k]) begin
				rem_n[k] = REM_W'(trial[k] - sub_v[k]);
				root_n[k] = {root_s[k][SQRT_STEPS-2:0], 1'b1};
			end else begin
				rem_n[k] = trial[k][REM_W-1:0];
				root_n[k] = {root_s[k][SQRT_STEPS-2:0], 1'b0};
			end
		end
	end

	// one quotient bit per stage, three lanes share the divisor
	always_comb begin
		for (int j = 0; j < QUO_BITS; j++) begin
			dvs[j] = (DIV_W+2)'(len_s[j]) << (QUO_BITS - 1 - j);
			for (int i = 0; i < 3; i++) begin
				if ({2'b00, drem_s[j][i]} >= dvs[j]) begin
					drem_n[j][i] = drem_s[j][i] - dvs[j][DIV_W-1:0];
					quo_n[j][i] = {quo_s[j][i][QUO_BITS-2:0], 1'b1};
				end else begin
					drem_n[j][i] = drem_s[j][i];
					quo_n[j][i] = {quo_s[j][i][QUO_BITS-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_a[i];
				neg_s1[i] <= vec[i][16];
				sqr_s1[i] <= 32'(mag_a[i]) * 32'(mag_a[i]);
			end

			sq_s[0] <= SQ_W'(sqr_s1[0]) + SQ_W'(sqr_s1[1]) + SQ_W'(sqr_s1[2]);
			rem_s[0] <= '0;
			root_s[0] <= '0;
			mag_s[0] <= mag_s1;
			neg_s[0] <= neg_s1;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rem_s[k+1] <= rem_n[k];
				root_s[k+1] <= root_n[k];
				sq_s[k+1] <= sq_s[k];
				mag_s[k+1] <= mag_s[k];
				neg_s[k+1] <= neg_s[k];
			end

			len_s[0] <= root_s[SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				drem_s[0][i] <= {mag_s[SQRT_STEPS][i], {FRAC_SH{1'b0}}};
				quo_s[0][i] <= '0;
				dneg_s[0][i] <= neg_s[SQRT_STEPS][i];
			end
			for (int j = 0; j < QUO_BITS; j++) begin
				len_s[j+1] <= len_s[j];
				drem_s[j+1] <= drem_n[j];
				quo_s[j+1] <= quo_n[j];
				dneg_s[j+1] <= dneg_s[j];
			end

			// a zero-length vector has a zero root and maps to the zero vector
			for (int i = 0; i < 3; i++) begin
				if (len_s[QUO_BITS] == '0)
					unit[i] <= '0;
				else if (dneg_s[QUO_BITS][i])
					unit[i] <= unit_t'(16'd0 - 16'(quo_s[QUO_BITS][i]));
				else
					unit[i] <= unit_t'(16'(quo_s[QUO_BITS][i]));
			end
		end
	end

endmodule

// File: src/pfl_shade.sv
module pfl_shade import pfl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  tag_t               in_tag,
	input  unit_t              n        [3],
	input  unit_t              l        [3],
	input  unit_t              v        [3],
	input  logic [47:0]        ambient,
	input  logic [47:0]        diffuse,
	input  logic [47:0]        specular,
	input  logic [SHIN_W-1:0]  shin,
	output logic               out_vld,
	output tag_t               out_tag,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue
);

	localparam int SUM_W = 18;
	localparam int SCL_W = SUM_W + COLOR_FRAC_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s23;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s23;

	unit_t n_s1 [3], l_s1 [3], v_s1 [3];
	logic signed [31:0] p_s1 [3];
	unit_t n_s2 [3], l_s2 [3], v_s2 [3];
	logic signed [31:0] ndl_s2;
	unit_t l_s3 [3], v_s3 [3];
	logic signed [47:0] m_s3 [3];
	logic [14:0] diff_s3;
	unit_t v_s4 [3];
	logic signed [18:0] r_s4 [3];
	logic [14:0] diff_s4;
	logic signed [34:0] pv_s5 [3];
	logic [14:0] diff_s5;

	logic        pvld_s  [POW_STEPS+1];
	tag_t        ptag_s  [POW_STEPS+1];
	logic [14:0] acc_s   [POW_STEPS+1];
	logic [14:0] base_s  [POW_STEPS+1];
	logic [14:0] pdiff_s [POW_STEPS+1];
	logic [29:0] prod    [POW_STEPS];
	logic [14:0] acc_n   [POW_STEPS];

	logic [30:0] cd_s23 [3];
	logic [30:0] cs_s23 [3];
	logic [SUM_W-1:0] csum [3];
	logic [SCL_W-1:0] cscl [3];
	logic [COLOR_W-1:0] csat [3];

	// square on even steps, conditional multiply by the base on odd steps
	always_comb begin
		for (int s = 0; s < POW_STEPS; s++) begin
			prod[s] = 30'(acc_s[s]) * 30'(((s & 1) == 0) ? acc_s[s] : base_s[s]);
			if (((s & 1) == 0) || shin[SHIN_W-1-(s >> 1)])
				acc_n[s] = 15'(prod[s] >> 14);
			else
				acc_n[s] = acc_s[s];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			csum[i] = SUM_W'(ambient[16*i +: 16]) + SUM_W'(cd_s23[i] >> 14)
				+ SUM_W'(cs_s23[i] >> 14);
			cscl[i] = {csum[i], {COLOR_FRAC_BITS{1'b0}}} >> 14;
			csat[i] = (cscl[i] > SCL_W'(COLOR_ONE)) ? COLOR_ONE : cscl[i][COLOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			pvld_s <= '{default: 1'b0};
			vld_s23 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			pvld_s[0] <= vld_s5;
			for (int s = 0; s < POW_STEPS; s++)
				pvld_s[s+1] <= pvld_s[s];
			vld_s23 <= pvld_s[POW_STEPS];
			out_vld <= vld_s23;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			n_s1 <= n;
			l_s1 <= l;
			v_s1 <= v;
			for (int i = 0; i < 3; i++)
				p_s1[i] <= 32'(n[i]) * 32'(l[i]);

			tag_s2 <= tag_s1;
			n_s2 <= n_s1;
			l_s2 <= l_s1;
			v_s2 <= v_s1;
			ndl_s2 <= p_s1[0] + p_s1[1] + p_s1[2];

			tag_s3 <= tag_s2;
			l_s3 <= l_s2;
			v_s3 <= v_s2;
			diff_s3 <= to_q14(37'(ndl_s2));
			for (int i = 0; i < 3; i++)
				m_s3[i] <= 48'(ndl_s2) * 48'(n_s2[i]);

			// reflection: floor of 2 (N.L) N over 2^28, minus L
			tag_s4 <= tag_s3;
			v_s4 <= v_s3;
			diff_s4 <= diff_s3;
			for (int i = 0; i < 3; i++)
				r_s4[i] <= 19'(m_s3[i] >>> 27) - 19'(l_s3[i]);

			tag_s5 <= tag_s4;
			diff_s5 <= diff_s4;
			for (int i = 0; i < 3; i++)
				pv_s5[i] <= 35'(v_s4[i]) * 35'(r_s4[i]);

			ptag_s[0] <= tag_s5;
			pdiff_s[0] <= diff_s5;
			acc_s[0] <= 15'(Q14_ONE);
			base_s[0] <= to_q14(37'(pv_s5[0]) + 37'(pv_s5[1]) + 37'(pv_s5[2]));
			for (int s = 0; s < POW_STEPS; s++) begin
				ptag_s[s+1] <= ptag_s[s];
				pdiff_s[s+1] <= pdiff_s[s];
				acc_s[s+1] <= acc_n[s];
				base_s[s+1] <= base_s[s];
			end

			tag_s23 <= ptag_s[POW_STEPS];
			for (int i = 0; i < 3; i++) begin
				cd_s23[i] <= 31'(pdiff_s[POW_STEPS]) * 31'(diffuse[16*i +: 16]);
				cs_s23[i] <= 31'(acc_s[POW_STEPS]) * 31'(specular[16*i +: 16]);
			end

			out_tag <= tag_s23;
			red <= csat[0];
			green <= csat[1];
			blue <= csat[2];
		end
	end

endmodule

// File: src/phong_fragment_lighting.sv
// Per-fragment Phong shading with one point light. A fragment beat (world position Q8.8,
// unnormalised normal Q1.14, window position) enters on every clock that the output is not
// stalled; one fragment per clock is then sustained because the 31-step square root and the
// 15-step dividers of the three normalisers are fully pipelined, one bit per stage.
// Back-pressure on the output freezes the whole pipeline. Registers pack x or red in bits
// 15:0, y or green in 31:16 and z or blue in 47:32; write them only while no fragment is in
// flight. Colours come out with COLOR_FRAC_BITS fraction bits, saturated at 1.0.
`include "phong_fragment_lighting_macros.svh"

module phong_fragment_lighting import pfl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [11:0]        win_x,
	input  logic [11:0]        win_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        out_win_x,
	output logic [11:0]        out_win_y,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	logic en;
	logic [47:0] light_q, view_q, ambient_q, diffuse_q, specular_q;
	logic [SHIN_W-1:0] shininess_q;

	logic signed [15:0] pos_a [3];
	logic signed [15:0] norm_a [3];
	raw_t nraw_s1 [3], lraw_s1 [3], vraw_s1 [3];
	logic valid_s1;
	tag_t tag_s1;

	logic lag_valid_s [UV_LAT];
	tag_t lag_tag_s [UV_LAT];

	unit_t n_u [3], l_u [3], v_u [3];
	tag_t res_tag;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	assign pos_a = '{pos_x, pos_y, pos_z};
	assign norm_a = '{norm_x, norm_y, norm_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= '0;
			view_q <= '0;
			ambient_q <= '0;
			diffuse_q <= '0;
			specular_q <= '0;
			shininess_q <= SHIN_W'(32);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIGHT_POS: light_q <= cfg_data;
				REG_VIEW_POS:  view_q <= cfg_data;
				REG_AMBIENT:   ambient_q <= cfg_data;
				REG_DIFFUSE:   diffuse_q <= cfg_data;
				REG_SPECULAR:  specular_q <= cfg_data;
				REG_SHININESS: shininess_q <= cfg_data[SHIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			lag_valid_s <= '{default: 1'b0};
		end else if (en) begin
			valid_s1 <= in_valid;
			lag_valid_s[0] <= valid_s1;
			for (int k = 1; k < UV_LAT; k++)
				lag_valid_s[k] <= lag_valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= '{win_x: win_x, win_y: win_y};
			for (int i = 0; i < 3; i++) begin
				nraw_s1[i] <= raw_t'(norm_a[i]);
				lraw_s1[i] <= raw_t'($signed(light_q[16*i +: 16])) - raw_t'(pos_a[i]);
				vraw_s1[i] <= raw_t'($signed(view_q[16*i +: 16])) - raw_t'(pos_a[i]);
			end
			lag_tag_s[0] <= tag_s1;
			for (int k = 1; k < UV_LAT; k++)
				lag_tag_s[k] <= lag_tag_s[k-1];
		end
	end

	pfl_unit_vec u_norm (
		.clk  (clk),
		.en   (en),
		.vec  (nraw_s1),
		.unit (n_u)
	);

	pfl_unit_vec u_light (
		.clk  (clk),
		.en   (en),
		.vec  (lraw_s1),
		.unit (l_u)
	);

	pfl_unit_vec u_view (
		.clk  (clk),
		.en   (en),
		.vec  (vraw_s1),
		.unit (v_u)
	);

	pfl_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (lag_valid_s[UV_LAT-1]),
		.in_tag   (lag_tag_s[UV_LAT-1]),
		.n        (n_u),
		.l        (l_u),
		.v        (v_u),
		.ambient  (ambient_q),
		.diffuse  (diffuse_q),
		.specular (specular_q),
		.shin     (shininess_q),
		.out_vld  (out_valid),
		.out_tag  (res_tag),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign out_win_x = res_tag.win_x;
	assign out_win_y = res_tag.win_y;

	`PFL_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && in_ready, valid_s1, "accepted beat lost at entry")
	`PFL_ASSERT_IMP(a_colour_sat, clk, arst_n, out_valid, red <= COLOR_ONE && green <= COLOR_ONE && blue <= COLOR_ONE, "colour above 1.0")
	`PFL_ASSERT_NEXT(a_shin_write, clk, arst_n, cfg_valid && cfg_ready && cfg_index == REG_SHININESS, shininess_q == $past(cfg_data[SHIN_W-1:0]), "shininess write lost")
	`PFL_ASSERT_IMP(a_unit_range, clk, arst_n, lag_valid_s[UV_LAT-1], n_u[0] <= Q14_ONE && n_u[0] >= -Q14_ONE && l_u[1] <= Q14_ONE && l_u[1] >= -Q14_ONE && v_u[2] <= Q14_ONE && v_u[2] >= -Q14_ONE, "unit vector component above 1.0")

endmodule
